/* hdl/assert_macros.svh */
// Assertion macros for the port checker of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is low.
`define ASSERT_NORST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* hdl/ffd_pkg.sv */
// Types, constants and helpers of the form field extract/decode block.
// No dependencies.
package ffd_pkg;

  localparam int NAME_BYTES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int CAP_W           = 9;
  localparam int LEN_W           = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_NAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAP   = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [CAP_W-1:0] VALUE_CAP_RESET = 9'd64;
  localparam logic [LEN_W-1:0] NAME_LEN_RESET  = 4'd1;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // Results caused by one body byte: up to three value bytes, then an
  // optional done item.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            done;
    logic            found;
  } ffd_bundle_t;

  // {is_hex, digit value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

/* hdl/ffd_front.sv */
// Front end: configuration registers, name matching and percent decoding.
// Turns each body byte into a result bundle. Depends on ffd_pkg.
module ffd_front import ffd_pkg::*; #(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 body_valid,
  output logic                 body_ready,
  input  logic [7:0]           body_byte,
  input  logic                 end_of_body,
  output logic                 push,
  output ffd_bundle_t          push_data,
  input  logic                 push_ready
);

  localparam int NAME_W = NAME_BYTES * 8;

  logic [NAME_W-1:0] field_name;
  logic [LEN_W-1:0]  name_length;
  logic [CAP_W-1:0]  value_capacity;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] name_pos, name_pos_next;
  logic [1:0]       esc, esc_next;
  logic [7:0]       held, held_next;
  logic [CAP_W-1:0] emitted, emitted_next;

  logic [LEN_W-1:0]  len;
  logic [NAME_W-1:0] name_sh;
  logic [7:0]        want;
  logic              accept;

  logic [2:0][7:0] cand;
  logic [1:0]      ncand;
  logic [1:0]      nemit;
  logic            done;
  logic            found;
  logic [CAP_W:0]  room;

  assign body_ready = push_ready;
  assign accept     = body_valid && body_ready;

  assign len     = (name_length > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : name_length;
  assign name_sh = field_name >> {name_pos, 3'b000};
  assign want    = name_sh[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      field_name     <= '0;
      name_length    <= NAME_LEN_RESET;
      value_capacity <= VALUE_CAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FIELD_NAME:  field_name     <= cfg_data[NAME_W-1:0];
        CFG_NAME_LENGTH: name_length    <= cfg_data[LEN_W-1:0];
        CFG_VALUE_CAP:   value_capacity <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [4:0] hb;
    logic [4:0] hh;
    hb            = hex_val(body_byte);
    hh            = hex_val(held);
    phase_next    = phase;
    name_pos_next = name_pos;
    esc_next      = esc;
    held_next     = held;
    emitted_next  = emitted;
    cand          = '0;
    ncand         = 2'd0;
    done          = 1'b0;
    found         = 1'b0;

    unique case (phase)
      PH_MATCH: begin
        if (name_pos < len) begin
          if (body_byte == want) begin
            name_pos_next = name_pos + 1'b1;
          end else begin
            name_pos_next = '0;
            phase_next    = (body_byte == CH_AMP) ? PH_MATCH : PH_SKIP;
          end
        end else if (body_byte == CH_EQUAL) begin
          phase_next   = PH_VALUE;
          esc_next     = 2'd0;
          emitted_next = '0;
        end else begin
          name_pos_next = '0;
          phase_next    = (body_byte == CH_AMP) ? PH_MATCH : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (body_byte == CH_AMP) begin
          phase_next    = PH_MATCH;
          name_pos_next = '0;
        end
      end
      PH_VALUE: begin
        if (body_byte == CH_AMP) begin
          if (esc != 2'd0) begin
            cand[ncand] = CH_PERCENT;
            ncand       = ncand + 1'b1;
          end
          if (esc == 2'd2) begin
            cand[ncand] = held;
            ncand       = ncand + 1'b1;
          end
          esc_next   = 2'd0;
          done       = 1'b1;
          found      = 1'b1;
          phase_next = PH_DONE;
        end else begin
          if (esc == 2'd1 && hb[4]) begin
            held_next = body_byte;
            esc_next  = 2'd2;
          end else if (esc == 2'd2 && hb[4]) begin
            esc_next    = 2'd0;
            cand[ncand] = {hh[3:0], hb[3:0]};
            ncand       = ncand + 1'b1;
          end else begin
            esc_next = 2'd0;
            if (esc != 2'd0) begin
              cand[ncand] = CH_PERCENT;
              ncand       = ncand + 1'b1;
            end
            if (esc == 2'd2) begin
              cand[ncand] = held;
              ncand       = ncand + 1'b1;
            end
            if (body_byte == CH_PLUS) begin
              cand[ncand] = CH_SPACE;
              ncand       = ncand + 1'b1;
            end else if (body_byte == CH_PERCENT) begin
              esc_next = 2'd1;
            end else begin
              cand[ncand] = body_byte;
              ncand       = ncand + 1'b1;
            end
          end
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (end_of_body) begin
      if (phase_next == PH_VALUE) begin
        if (esc_next != 2'd0) begin
          cand[ncand] = CH_PERCENT;
          ncand       = ncand + 1'b1;
        end
        if (esc_next == 2'd2) begin
          cand[ncand] = held_next;
          ncand       = ncand + 1'b1;
        end
        done  = 1'b1;
        found = 1'b1;
      end else if (phase_next != PH_DONE) begin
        done  = 1'b1;
        found = 1'b0;
      end
    end

    // Value bytes beyond the capacity minus one are dropped (one slot is held back); once one drops, all later do.
    room  = (value_capacity > ({1'b0, emitted_next} + 1'b1))
            ? ({1'b0, value_capacity} - {1'b0, emitted_next} - 1'b1) : '0;
    nemit = (room < {{(CAP_W-1){1'b0}}, ncand}) ? room[1:0] : ncand;
    emitted_next = emitted_next + CAP_W'(nemit);
  end

  assign push_data.bytes  = cand;
  assign push_data.nbytes = nemit;
  assign push_data.done   = done;
  assign push_data.found  = found;
  assign push = accept && (nemit != 2'd0 || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MATCH;
      name_pos <= '0;
      esc      <= 2'd0;
      held     <= '0;
      emitted  <= '0;
    end else if (accept) begin
      if (end_of_body) begin
        phase    <= PH_MATCH;
        name_pos <= '0;
        esc      <= 2'd0;
        held     <= '0;
        emitted  <= '0;
      end else begin
        phase    <= phase_next;
        name_pos <= name_pos_next;
        esc      <= esc_next;
        held     <= held_next;
        emitted  <= emitted_next;
      end
    end
  end

endmodule

/* hdl/ffd_queue.sv */
// Small bundle queue between the front and back ends.
// Depends on ffd_pkg.
module ffd_queue import ffd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ffd_bundle_t push_data,
  output logic        push_ready,
  output logic        head_valid,
  output ffd_bundle_t head,
  input  logic        pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ffd_bundle_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/ffd_back.sv */
// Back end: walks the head bundle one result transaction at a time into the
// output register. Depends on ffd_pkg.
module ffd_back import ffd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  ffd_bundle_t head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  value_byte,
  output logic        byte_valid,
  output logic        found,
  output logic        last
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       last_item;
  logic       load;
  logic       is_byte;

  assign total     = {1'b0, head.nbytes} + {2'b00, head.done};
  assign last_item = ({1'b0, idx} == (total - 1'b1));
  assign load      = head_valid && (!result_valid || result_ready);
  assign pop       = load && last_item;
  assign is_byte   = (idx < head.nbytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= 2'd0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx          <= last_item ? 2'd0 : idx + 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_byte <= is_byte ? head.bytes[idx] : 8'h00;
      byte_valid <= is_byte;
      found      <= is_byte ? 1'b0 : head.found;
      last       <= !is_byte;
    end
  end

endmodule

/* hdl/form_field_extract_decode.sv */
// Top level of the form field extract/decode block.
// Depends on ffd_pkg, ffd_front, ffd_queue, ffd_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   body     | body_valid / body_ready   | body_byte, end_of_body
//   result   | result_valid/result_ready | value_byte, byte_valid, found, last
//   config   | cfg_write                 | cfg_index, cfg_data
//
// One body byte is taken per cycle while the bundle queue has room.
// Each byte yields zero to four result transactions, sent one per cycle from
// the output register while result_ready is high; sustained input rate is set
// by the result drain rate. Each result is registered after the bundle queue.
// Reset (rst, synchronous) clears queue and parse state; config takes defaults.
module form_field_extract_decode import ffd_pkg::*; #(
  parameter int NAME_BYTES  = NAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 body_valid,
  output logic                 body_ready,
  input  logic [7:0]           body_byte,
  input  logic                 end_of_body,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [7:0]           value_byte,
  output logic                 byte_valid,
  output logic                 found,
  output logic                 last
);

  logic        push;
  logic        push_ready;
  ffd_bundle_t push_data;
  logic        head_valid;
  ffd_bundle_t head;
  logic        pop;

  ffd_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .body_valid  (body_valid),
    .body_ready  (body_ready),
    .body_byte   (body_byte),
    .end_of_body (end_of_body),
    .push        (push),
    .push_data   (push_data),
    .push_ready  (push_ready)
  );

  ffd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ffd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value_byte   (value_byte),
    .byte_valid   (byte_valid),
    .found        (found),
    .last         (last)
  );

endmodule

/* hdl/ffd_checker.sv */
// Port-level checker for form_field_extract_decode, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ffd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] value_byte,
  input logic       byte_valid,
  input logic       found,
  input logic       last
);

  logic        stall;
  logic        byte_item;
  logic        done_item;
  logic [10:0] payload;
  logic [8:0]  done_data;

  assign stall     = result_valid && !result_ready;
  assign byte_item = result_valid && byte_valid;
  assign done_item = result_valid && last;
  assign payload   = {value_byte, byte_valid, found, last};
  assign done_data = {byte_valid, value_byte};

  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !result_valid, "result valid after reset")
  `ASSERT_NORST(a_hold, clk, rst, stall |=> result_valid && $stable(payload), "result hold broken")
  `ASSERT_NORST(a_byte_item, clk, rst, byte_item |-> !found && !last, "value byte flagged done")
  `ASSERT_NORST(a_done_item, clk, rst, done_item |-> done_data == '0, "done carries a byte")

endmodule

bind form_field_extract_decode ffd_port_checker u_chk (.*);

/* bench/ffd_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the form field extract/decode block: predicts the result
// transactions of every accepted body byte and compares them in order.
// Depends on ffd_pkg.
module ffd_checker import ffd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 body_valid,
  input  logic                 body_ready,
  input  logic [7:0]           body_byte,
  input  logic                 end_of_body,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  logic [7:0]           value_byte,
  input  logic                 byte_valid,
  input  logic                 found,
  input  logic                 last,
  output int                   mismatch_count,
  output int                   results_owed
);

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       found;
    logic       last;
  } field_result_t;

  field_result_t decoded_q[$];

  logic [CFG_W-1:0] name_word;
  logic [LEN_W-1:0] name_size;
  logic [CAP_W-1:0] value_cap;

  phase_t           parse_phase;
  logic [3:0]       name_pos;
  logic [1:0]       esc_stage;
  logic [7:0]       held_hex;
  logic [CAP_W-1:0] emitted;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    if (c <= "9") return 4'(c - "0");
    if (c >= "a") return 4'(c - "a" + 8'd10);
    return 4'(c - "A" + 8'd10);
  endfunction

  task automatic push_result(input logic [7:0] b, input logic v, input logic f,
                             input logic l);
    decoded_q.push_back('{value_byte: b, byte_valid: v, found: f, last: l});
  endtask

  // Capacity counts the terminator, so one slot is always held back.
  task automatic emit_char(input logic [7:0] b);
    if (int'(emitted) + 1 < int'(value_cap)) begin
      push_result(b, 1'b1, 1'b0, 1'b0);
      emitted++;
    end
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == CH_PLUS) emit_char(CH_SPACE);
    else if (c == CH_PERCENT) esc_stage = ESC_PCT;
    else emit_char(c);
  endtask

  task automatic value_char(input logic [7:0] c);
    case (esc_stage)
      ESC_PCT: begin
        if (is_hex(c)) begin
          held_hex  = c;
          esc_stage = ESC_DIGIT;
        end else begin
          esc_stage = ESC_NONE;
          emit_char(CH_PERCENT);
          plain_char(c);
        end
      end
      ESC_DIGIT: begin
        esc_stage = ESC_NONE;
        if (is_hex(c)) begin
          emit_char({nibble(held_hex), nibble(c)});
        end else begin
          emit_char(CH_PERCENT);
          emit_char(held_hex);
          plain_char(c);
        end
      end
      default: plain_char(c);
    endcase
  endtask

  task automatic flush_escape();
    if (esc_stage == ESC_PCT) begin
      emit_char(CH_PERCENT);
    end else if (esc_stage == ESC_DIGIT) begin
      emit_char(CH_PERCENT);
      emit_char(held_hex);
    end
    esc_stage = ESC_NONE;
  endtask

  task automatic clear_parse();
    parse_phase = PH_MATCH;
    name_pos    = '0;
    esc_stage   = ESC_NONE;
    held_hex    = '0;
    emitted     = '0;
  endtask

  task automatic name_miss(input logic [7:0] c);
    name_pos    = '0;
    parse_phase = (c == CH_AMP) ? PH_MATCH : PH_SKIP;
  endtask

  task automatic decode_body_byte(input logic [7:0] b, input logic eob);
    logic [3:0] used_len;
    used_len = (name_size > NAME_BYTES_DEF) ? 4'(NAME_BYTES_DEF) : name_size;
    case (parse_phase)
      PH_MATCH: begin
        if (name_pos < used_len) begin
          if (b == name_word[8*name_pos[2:0] +: 8]) name_pos++;
          else name_miss(b);
        end else if (b == CH_EQUAL) begin
          parse_phase = PH_VALUE;
          esc_stage   = ESC_NONE;
          emitted     = '0;
        end else begin
          name_miss(b);
        end
      end
      PH_SKIP: begin
        if (b == CH_AMP) begin
          parse_phase = PH_MATCH;
          name_pos    = '0;
        end
      end
      PH_VALUE: begin
        if (b == CH_AMP) begin
          flush_escape();
          push_result(8'h00, 1'b0, 1'b1, 1'b1);
          parse_phase = PH_DONE;
        end else begin
          value_char(b);
        end
      end
      default: ;
    endcase
    if (eob) begin
      if (parse_phase == PH_VALUE) begin
        flush_escape();
        push_result(8'h00, 1'b0, 1'b1, 1'b1);
      end else if (parse_phase != PH_DONE) begin
        push_result(8'h00, 1'b0, 1'b0, 1'b1);
      end
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    field_result_t want;
    if (rst) begin
      decoded_q.delete();
      name_word = '0;
      name_size = NAME_LEN_RESET;
      value_cap = VALUE_CAP_RESET;
      clear_parse();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FIELD_NAME:  name_word = cfg_data;
          CFG_NAME_LENGTH: name_size = cfg_data[LEN_W-1:0];
          CFG_VALUE_CAP:   value_cap = cfg_data[CAP_W-1:0];
          default: ;
        endcase
      end
      if (body_valid && body_ready) decode_body_byte(body_byte, end_of_body);
      if (result_valid && result_ready) begin
        if (decoded_q.size() == 0) begin
          $error("%s value_byte=%0h byte_valid=%0b found=%0b last=%0b",
                 "result transaction with none expected:", value_byte, byte_valid,
                 found, last);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (value_byte !== want.value_byte) begin
            $error("value_byte: expected %0h, got %0h", want.value_byte, value_byte);
            mismatch_count++;
          end
          if (byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
            mismatch_count++;
          end
          if (found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found);
            mismatch_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            mismatch_count++;
          end
        end
      end
    end
    results_owed <= decoded_q.size();
  end

endmodule

/* bench/form_field_extract_decode_tb.sv */
`timescale 1ns / 1ps
// Top of the form field extract/decode testbench: clock, reset, register
// setup, form body stimulus and result back-pressure; checking is in ffd_checker.
// Depends on ffd_pkg, ffd_checker and the block itself.
module form_field_extract_decode_tb;
  import ffd_pkg::*;

  localparam int BODY_BYTES_TARGET = 160;
  localparam int MAX_GAP           = 13;
  localparam int LONG_HOLD         = 300;
  localparam int SETTLE_CYCLES     = 8;
  localparam int CYCLE_LIMIT       = 200000;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_FIELD_NAME;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 body_valid   = 1'b0;
  logic                 body_ready;
  logic [7:0]           body_byte    = 8'h00;
  logic                 end_of_body  = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [7:0]           value_byte;
  logic                 byte_valid;
  logic                 found;
  logic                 last;

  int         mismatch_count;
  int         results_owed;
  int         cycle_count = 0;
  int         bytes_sent  = 0;
  bit         tx_eager    = 1'b0;
  bit         rx_eager    = 1'b0;
  bit         hold_req    = 1'b0;
  logic [7:0] form_q[$];

  form_field_extract_decode u_dut (.*);

  ffd_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** form_field_extract_decode: FAILED **");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task automatic send_form_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      body_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_valid  <= 1'b1;
    body_byte   <= b;
    end_of_body <= eob;
    do @(posedge clk); while (!body_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_form_byte(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    body_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] nm, input logic [LEN_W-1:0] len,
                             input logic [CAP_W-1:0] cap);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FIELD_NAME;
    cfg_data  <= nm;
    @(negedge clk);
    cfg_index <= CFG_NAME_LENGTH;
    cfg_data  <= CFG_W'(len);
    @(negedge clk);
    cfg_index <= CFG_VALUE_CAP;
    cfg_data  <= CFG_W'(cap);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_value();
    string hexset;
    int    ntok;
    int    pick;
    hexset = "0123456789abcdefABCDEF";
    ntok = $urandom_range(0, 7);
    repeat (ntok) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: begin
          form_q.push_back(CH_PERCENT);
          form_q.push_back(hexset[$urandom_range(0, 21)]);
          form_q.push_back(hexset[$urandom_range(0, 21)]);
        end
        3: form_q.push_back(CH_PERCENT);
        4: begin
          form_q.push_back(CH_PERCENT);
          form_q.push_back(hexset[$urandom_range(0, 21)]);
          form_q.push_back(8'("g") + 8'($urandom_range(0, 19)));
        end
        5: form_q.push_back(CH_PLUS);
        6: form_q.push_back(8'($urandom_range(0, 255)));
        default: form_q.push_back(8'("a") + 8'($urandom_range(0, 25)));
      endcase
    end
  endtask

  // Mostly well-formed name=value segments; the rest cut names, other
  // fields and raw noise.
  task automatic build_form_body(input logic [CFG_W-1:0] nm, input int used_len);
    int nseg;
    int kind;
    int cut;
    form_q.delete();
    nseg = $urandom_range(1, 3);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) form_q.push_back(CH_AMP);
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        for (int i = 0; i < used_len; i++) form_q.push_back(nm[8*i +: 8]);
        form_q.push_back(CH_EQUAL);
        add_value();
      end else if (kind < 15) begin
        cut = $urandom_range(0, used_len);
        for (int i = 0; i < cut; i++) form_q.push_back(nm[8*i +: 8]);
        form_q.push_back(8'("a") + 8'($urandom_range(0, 3)));
        form_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 18) begin
        form_q.push_back("z");
        form_q.push_back("q");
        form_q.push_back(CH_EQUAL);
        add_value();
      end else begin
        repeat ($urandom_range(1, 4)) form_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] letter_name();
    logic [CFG_W-1:0] nm;
    for (int i = 0; i < 8; i++) nm[8*i +: 8] = 8'("a") + 8'($urandom_range(0, 3));
    return nm;
  endfunction

  // Result side: random stalls per transaction, one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if ($urandom_range(0, 19) == 0) rx_eager = !rx_eager;
      gap = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  initial begin
    int               phase_idx;
    int               used_len;
    logic [CFG_W-1:0] nm;
    logic [LEN_W-1:0] len;
    logic [CAP_W-1:0] cap;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed bodies
    load_config(CFG_W'("k"), 4'd1, 9'd64);
    send_text("k=%41+%4g%&z");
    send_form_byte("k", 1'b0);
    send_form_byte(CH_EQUAL, 1'b0);
    send_form_byte(8'h00, 1'b0);
    send_form_byte(8'hFF, 1'b0);
    send_form_byte(CH_PERCENT, 1'b0);
    send_form_byte("4", 1'b1);
    send_text("q");
    drain();
    load_config({$urandom, $urandom}, 4'd0, 9'd0);
    send_text("=a");
    drain();

    // Long result hold-off while a long value keeps arriving
    load_config(CFG_W'("k"), 4'd1, 9'd256);
    hold_req = 1'b1;
    send_text("k=abcdefghijklmn");
    drain();

    // Random bodies under a rotation of register settings
    phase_idx = 0;
    while (bytes_sent < BODY_BYTES_TARGET || phase_idx < 6) begin
      nm = letter_name();
      case (phase_idx % 6)
        0: begin len = 4'd2;  cap = 9'd4;   end
        1: begin len = 4'd3;  cap = 9'd256; nm[15:8] = CH_AMP; end
        2: begin len = 4'd8;  cap = 9'd1;   nm = {$urandom, $urandom}; end
        3: begin len = 4'd15; cap = 9'd64;  end
        4: begin len = 4'd0;  cap = 9'd0;   end
        default: begin len = 4'd1; cap = 9'($urandom_range(2, 12)); end
      endcase
      used_len = (len > 4'd8) ? 8 : int'(len);
      drain();
      load_config(nm, len, cap);
      if ($urandom_range(0, 3) == 0) tx_eager = !tx_eager;
      build_form_body(nm, used_len);
      for (int i = 0; i < form_q.size(); i++)
        send_form_byte(form_q[i], i == form_q.size() - 1);
      phase_idx++;
    end
    drain();

    if (mismatch_count == 0) begin
      $display("** form_field_extract_decode: PASSED **");
    end else begin
      $display("** form_field_extract_decode: FAILED **");
    end
    $finish;
  end

endmodule
